FILE: rtl/core/oas_pkg.sv
package oas_pkg;

   localparam int DIST_W        = 12;
   localparam int WAIT_CFG_W    = 12;
   localparam int COUNT_W       = 4;
   localparam int SPEED_W       = 7;
   localparam int ANGLE_W       = 8;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 12;
   localparam int DISTANCE_BITS = 12;
   localparam int WAIT_BITS     = 12;

   localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(100);

   localparam logic [ANGLE_W-1:0] ANG_LEFT   = ANGLE_W'(30);
   localparam logic [ANGLE_W-1:0] ANG_CENTRE = ANGLE_W'(90);
   localparam logic [ANGLE_W-1:0] ANG_RIGHT  = ANGLE_W'(150);

   localparam logic [DIST_W-1:0]     RST_FRONT_LIMIT = DIST_W'(25);
   localparam logic [COUNT_W-1:0]    RST_CONFIRM     = COUNT_W'(2);
   localparam logic [WAIT_CFG_W-1:0] RST_SCAN_WAIT   = WAIT_CFG_W'(250);
   localparam logic [WAIT_CFG_W-1:0] RST_TURN_TIME   = WAIT_CFG_W'(500);
   localparam logic [WAIT_CFG_W-1:0] RST_POLL        = WAIT_CFG_W'(60);
   localparam logic [WAIT_CFG_W-1:0] RST_RESUME      = WAIT_CFG_W'(100);
   localparam logic [SPEED_W-1:0]    RST_FWD_SPEED   = SPEED_W'(60);
   localparam logic [SPEED_W-1:0]    RST_TURN_SPEED  = SPEED_W'(100);

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_MEASURE    = 3'd1,
      PH_WAIT_LEFT  = 3'd2,
      PH_WAIT_RIGHT = 3'd3,
      PH_TURN       = 3'd4,
      PH_FORWARD    = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      MOT_STOP  = 2'd0,
      MOT_FWD   = 2'd1,
      MOT_LEFT  = 2'd2,
      MOT_RIGHT = 2'd3
   } motor_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRONT_LIMIT = 3'd0,
      CSR_CONFIRM     = 3'd1,
      CSR_SCAN_WAIT   = 3'd2,
      CSR_TURN_TIME   = 3'd3,
      CSR_POLL        = 3'd4,
      CSR_RESUME      = 3'd5,
      CSR_FWD_SPEED   = 3'd6,
      CSR_TURN_SPEED  = 3'd7
   } csr_addr_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [DIST_W-1:0] distance_cm;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         motor_cmd;
      logic [SPEED_W-1:0] motor_speed;
      logic [ANGLE_W-1:0] servo_angle;
      logic               running;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] data;
   } csr_payload_type;

   function automatic logic [SPEED_W-1:0] clamp_speed(input logic [SPEED_W-1:0] v);
      return (v > SPEED_MAX) ? SPEED_MAX : v;
   endfunction

endpackage

FILE: rtl/core/oas_chan_if.sv
interface oas_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/obstacle_avoid_scan_sequencer.sv
// One result per item, valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the result register is the only stage, and
// a new item is taken whenever that register is empty or being drained.
// Configuration writes take effect from the next cycle; the write port is always ready.
// Reset (synchronous, active high): registers to defaults, phase idle, not
// running, motor stopped, servo centered, no result pending.
module obstacle_avoid_scan_sequencer #(
   parameter int DISTANCE_BITS = oas_pkg::DISTANCE_BITS,
   parameter int WAIT_BITS     = oas_pkg::WAIT_BITS
) (
   input logic clock,
   input logic reset,
   oas_chan_if.sink   req,
   oas_chan_if.source rsp,
   oas_chan_if.sink   csr
);
   import oas_pkg::*;

   localparam int DCMP_W = (DISTANCE_BITS > DIST_W) ? DISTANCE_BITS : DIST_W;
   localparam int WCMP_W = (WAIT_BITS > WAIT_CFG_W) ? WAIT_BITS : WAIT_CFG_W;
   localparam logic [DCMP_W-1:0] DIST_MAX =
      DCMP_W'((64'd1 << DISTANCE_BITS) - 64'd1);
   localparam logic [WCMP_W-1:0] WAIT_MAX =
      WCMP_W'((64'd1 << WAIT_BITS) - 64'd1);

   function automatic logic [WAIT_BITS-1:0] sat_wait(input logic [WAIT_CFG_W-1:0] v);
      logic [WCMP_W-1:0] ve;
      ve = WCMP_W'(v);
      return (ve > WAIT_MAX) ? WAIT_BITS'(WAIT_MAX) : WAIT_BITS'(ve);
   endfunction

   // configuration
   logic [DIST_W-1:0]     front_limit_ff;
   logic [COUNT_W-1:0]    confirm_ff;
   logic [WAIT_CFG_W-1:0] scan_wait_ff, turn_time_ff, poll_ff, resume_ff;
   logic [SPEED_W-1:0]    fwd_speed_ff, turn_speed_ff;

   // sequencer state
   phase_type                phase_ff, phase_in;
   logic                     active_ff, active_in;
   logic [WAIT_BITS-1:0]     wait_ff, wait_in;
   logic [COUNT_W-1:0]       near_ff, near_in;
   logic [DISTANCE_BITS-1:0] left_dist_ff, left_dist_in;
   motor_type                motor_ff, motor_in;
   logic [ANGLE_W-1:0]       servo_ff, servo_in;

   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            rsp_valid_ff;

   logic              req_fire;
   logic              csr_fire;
   logic [DCMP_W-1:0] dist_sat;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign csr_fire  = csr.valid;

   assign dist_sat = (DCMP_W'(req.payload.distance_cm) > DIST_MAX) ?
                     DIST_MAX : DCMP_W'(req.payload.distance_cm);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_limit_ff <= RST_FRONT_LIMIT;
         confirm_ff     <= RST_CONFIRM;
         scan_wait_ff   <= RST_SCAN_WAIT;
         turn_time_ff   <= RST_TURN_TIME;
         poll_ff        <= RST_POLL;
         resume_ff      <= RST_RESUME;
         fwd_speed_ff   <= RST_FWD_SPEED;
         turn_speed_ff  <= RST_TURN_SPEED;
      end else if (csr_fire) begin
         case (csr_addr_type'(csr.payload.addr))
            CSR_FRONT_LIMIT: front_limit_ff <= DIST_W'(csr.payload.data);
            CSR_CONFIRM:     confirm_ff     <= COUNT_W'(csr.payload.data);
            CSR_SCAN_WAIT:   scan_wait_ff   <= WAIT_CFG_W'(csr.payload.data);
            CSR_TURN_TIME:   turn_time_ff   <= WAIT_CFG_W'(csr.payload.data);
            CSR_POLL:        poll_ff        <= WAIT_CFG_W'(csr.payload.data);
            CSR_RESUME:      resume_ff      <= WAIT_CFG_W'(csr.payload.data);
            CSR_FWD_SPEED:   fwd_speed_ff   <= SPEED_W'(csr.payload.data);
            CSR_TURN_SPEED:  turn_speed_ff  <= SPEED_W'(csr.payload.data);
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [WAIT_BITS-1:0] wait_dec;
      logic [COUNT_W-1:0]   near_inc;

      phase_in     = phase_ff;
      active_in    = active_ff;
      wait_in      = wait_ff;
      near_in      = near_ff;
      left_dist_in = left_dist_ff;
      motor_in     = motor_ff;
      servo_in     = servo_ff;
      wait_dec     = (wait_ff != '0) ? wait_ff - WAIT_BITS'(1) : '0;
      near_inc     = (near_ff < confirm_ff) ? near_ff + COUNT_W'(1) : near_ff;

      case (req.payload.op)
         OP_TICK: begin
            if (active_ff) begin
               wait_in = wait_dec;
               if (wait_dec == '0) begin
                  case (phase_ff)
                     PH_MEASURE: begin
                        if (dist_sat > DCMP_W'(front_limit_ff)) begin
                           near_in  = '0;
                           motor_in = MOT_FWD;
                           phase_in = PH_FORWARD;
                           wait_in  = sat_wait(poll_ff);
                        end else begin
                           near_in = near_inc;
                           if (near_inc >= confirm_ff) begin
                              motor_in = MOT_STOP;
                              servo_in = ANG_LEFT;
                              phase_in = PH_WAIT_LEFT;
                              wait_in  = sat_wait(scan_wait_ff);
                           end else begin
                              motor_in = MOT_FWD;
                              phase_in = PH_FORWARD;
                              wait_in  = sat_wait(poll_ff);
                           end
                        end
                     end
                     PH_FORWARD: begin
                        phase_in = PH_MEASURE;
                        wait_in  = sat_wait(poll_ff);
                     end
                     PH_WAIT_LEFT: begin
                        left_dist_in = DISTANCE_BITS'(dist_sat);
                        servo_in     = ANG_RIGHT;
                        phase_in     = PH_WAIT_RIGHT;
                        wait_in      = sat_wait(scan_wait_ff);
                     end
                     PH_WAIT_RIGHT: begin
                        near_in  = '0;
                        servo_in = ANG_CENTRE;
                        // left wins a tie
                        motor_in = (DCMP_W'(left_dist_ff) >= dist_sat) ? MOT_LEFT : MOT_RIGHT;
                        phase_in = PH_TURN;
                        wait_in  = sat_wait(turn_time_ff);
                     end
                     PH_TURN: begin
                        motor_in = MOT_FWD;
                        phase_in = PH_FORWARD;
                        wait_in  = sat_wait(resume_ff);
                     end
                     default: begin
                        motor_in = MOT_STOP;
                        phase_in = PH_MEASURE;
                        wait_in  = sat_wait(scan_wait_ff);
                     end
                  endcase
               end
            end
         end
         OP_START: begin
            motor_in  = MOT_STOP;
            servo_in  = ANG_CENTRE;
            active_in = 1'b1;
            phase_in  = PH_MEASURE;
            near_in   = '0;
            wait_in   = sat_wait(scan_wait_ff);
         end
         OP_STOP: begin
            active_in = 1'b0;
            phase_in  = PH_IDLE;
            near_in   = '0;
            servo_in  = ANG_CENTRE;
            motor_in  = MOT_STOP;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_data_in.motor_cmd   = motor_in;
      rsp_data_in.servo_angle = servo_in;
      rsp_data_in.running     = active_in;
      case (motor_in)
         MOT_STOP: rsp_data_in.motor_speed = '0;
         MOT_FWD:  rsp_data_in.motor_speed = clamp_speed(fwd_speed_ff);
         default:  rsp_data_in.motor_speed = clamp_speed(turn_speed_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         active_ff    <= 1'b0;
         wait_ff      <= '0;
         near_ff      <= '0;
         left_dist_ff <= '0;
         motor_ff     <= MOT_STOP;
         servo_ff     <= ANG_CENTRE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff     <= phase_in;
            active_ff    <= active_in;
            wait_ff      <= wait_in;
            near_ff      <= near_in;
            left_dist_ff <= left_dist_in;
            motor_ff     <= motor_in;
            servo_ff     <= servo_in;
         end
         // hold the result until taken, refill on the same edge it drains
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   a_active_phase: assert property (@(posedge clock) disable iff (reset)
      active_ff == (phase_ff != PH_IDLE))
      else $error("running flag disagrees with phase");

   a_stop_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.motor_cmd == MOT_STOP) |-> rsp_data_ff.motor_speed == '0)
      else $error("nonzero speed reported with motor stopped");

   a_stop_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req.payload.op == OP_STOP) |=>
         rsp_valid_ff && !rsp_data_ff.running && (rsp_data_ff.servo_angle == ANG_CENTRE))
      else $error("stop item did not report idle result");

   a_scan_servo: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WAIT_LEFT) |-> (servo_ff == ANG_LEFT) && (motor_ff == MOT_STOP))
      else $error("left scan without servo left and motor stopped");

endmodule
